### design/kwm_pkg.sv
package kwm_pkg;

    // sizes
    localparam int MAX_SERIES  = 16;
    localparam int IDX_W       = 4;
    localparam int TIME_W      = 64;
    localparam int BITS_W      = 64;
    localparam int CNT_W       = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SERIES_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCENDING   = 1'd1;

    // input function codes
    localparam logic FUNC_OFFER  = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef logic [TIME_W-1:0]     stamp_t;
    typedef logic [BITS_W-1:0]     sample_t;
    typedef logic [MAX_SERIES-1:0] mask_t;

    // winner of the head comparison
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

endpackage

### design/kwm_in_if.sv
interface kwm_in_if;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [3:0]           series_index;
    kwm_pkg::stamp_t      sample_time;
    kwm_pkg::sample_t     sample_bits;

    modport source (output valid, output func, output series_index,
                    output sample_time, output sample_bits, input ready);
    modport sink   (input valid, input func, input series_index,
                    input sample_time, input sample_bits, output ready);

endinterface

### design/kwm_out_if.sv
interface kwm_out_if;

    logic                 valid;
    logic                 ready;
    kwm_pkg::stamp_t      out_time;
    kwm_pkg::sample_t     out_bits;
    logic [3:0]           refill_series;
    logic                 merge_end;

    modport source (output valid, output out_time, output out_bits,
                    output refill_series, output merge_end, input ready);
    modport sink   (input valid, input out_time, input out_bits,
                    input refill_series, input merge_end, output ready);

endinterface

### design/kwm_pick.sv
module kwm_pick
(
    input  kwm_pkg::mask_t  cand,
    input  kwm_pkg::stamp_t leaf_time [kwm_pkg::MAX_SERIES],
    input  logic            descending,
    output kwm_pkg::pick_t  pick
);

    localparam int NODES = 2 * kwm_pkg::MAX_SERIES - 1;

    logic                      node_found [NODES];
    logic [kwm_pkg::IDX_W-1:0] node_idx   [NODES];
    kwm_pkg::stamp_t           node_time  [NODES];

    // tournament tree, left child holds lower indexes so ties go left
    always_comb
    begin
        int   lc;
        int   rc;
        logic take_r;
        for (int i = 0; i < kwm_pkg::MAX_SERIES; i++)
        begin
            node_found[kwm_pkg::MAX_SERIES - 1 + i] = cand[i];
            node_idx[kwm_pkg::MAX_SERIES - 1 + i]   = kwm_pkg::IDX_W'(i);
            node_time[kwm_pkg::MAX_SERIES - 1 + i]  = leaf_time[i];
        end
        for (int k = kwm_pkg::MAX_SERIES - 2; k >= 0; k--)
        begin
            lc = 2 * k + 1;
            rc = 2 * k + 2;
            take_r = !node_found[lc] ||
                     (node_found[rc] && (descending ? (node_time[rc] > node_time[lc])
                                                    : (node_time[rc] < node_time[lc])));
            node_found[k] = take_r ? node_found[rc] : node_found[lc];
            node_idx[k]   = take_r ? node_idx[rc]   : node_idx[lc];
            node_time[k]  = take_r ? node_time[rc]  : node_time[lc];
        end
    end

    assign pick.found = node_found[0];
    assign pick.idx   = node_idx[0];

endmodule

### design/kway_timestamp_merge_unit.sv
// k-way timestamp merge
//
// sample_in carries one beat per offer: func selects a sample offer or an
// end-of-series notice for series_index. merge_out carries one beat per
// merged sample (out_time, out_bits, refill_series) and finally a single
// beat with merge_end set once every series in use is exhausted. After a
// sample beat the upstream source must offer the next sample of
// refill_series (or its end notice) before the merge can continue.
// series_count and descending are written through cfg_we / cfg_index /
// cfg_data while no beat is in flight.
//
// a beat accepted into the input register is decided there, and its result is
// loaded into the result register that drives merge_out once it has room.
// throughput: one beat per cycle while merge_out is not stalled; the head
// comparison is a 16-leaf comparator tree between the input register and the
// result register. a stalled merge_out holds the result register; sample_in
// keeps taking a beat while the input register is empty, then waits for the
// result register to drain.
// reset clears all heads, end notices, the end marker flag, and sets
// series_count to one and descending to zero.
module kway_timestamp_merge_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    kwm_in_if.sink                             sample_in,
    kwm_out_if.source                          merge_out,
    input  logic                               cfg_we,
    input  logic [kwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [kwm_pkg::CNT_W-1:0] series_count_reg;
    logic                      descending_reg;

    // input register
    logic                      s1_valid_reg;
    logic                      s1_func_reg;
    logic [kwm_pkg::IDX_W-1:0] s1_idx_reg;
    kwm_pkg::stamp_t           s1_time_reg;
    kwm_pkg::sample_t          s1_bits_reg;

    // merge state
    kwm_pkg::stamp_t           head_time_reg  [kwm_pkg::MAX_SERIES];
    kwm_pkg::sample_t          head_value_reg [kwm_pkg::MAX_SERIES];
    kwm_pkg::mask_t            head_valid_reg;
    kwm_pkg::mask_t            head_valid_next;
    kwm_pkg::mask_t            finished_reg;
    kwm_pkg::mask_t            finished_next;
    logic                      end_sent_reg;
    logic                      end_sent_next;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    kwm_pkg::stamp_t           out_time_reg;
    kwm_pkg::sample_t          out_bits_reg;
    logic [kwm_pkg::IDX_W-1:0] out_series_reg;
    logic                      out_end_reg;

    // decision logic
    logic                      proc_go;
    kwm_pkg::mask_t            in_use;
    kwm_pkg::mask_t            idx_bit;
    logic                      hit;
    logic                      take_sample;
    logic                      take_finish;
    kwm_pkg::mask_t            valid_mid;
    kwm_pkg::mask_t            finished_mid;
    kwm_pkg::mask_t            cand;
    kwm_pkg::stamp_t           leaf_time [kwm_pkg::MAX_SERIES];
    kwm_pkg::pick_t            pick;
    logic                      all_ready;
    logic                      emit;
    kwm_pkg::stamp_t           win_time;
    kwm_pkg::sample_t          win_bits;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_count_reg <= kwm_pkg::CNT_W'(1);
            descending_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kwm_pkg::CFG_SERIES_COUNT: series_count_reg <= cfg_data[kwm_pkg::CNT_W-1:0];
                kwm_pkg::CFG_DESCENDING:   descending_reg   <= cfg_data[0];
            endcase
        end
    end

    // handshake
    assign proc_go         = s1_valid_reg && (!out_valid_reg || merge_out.ready);
    assign sample_in.ready = !s1_valid_reg || proc_go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            s1_func_reg <= sample_in.func;
            s1_idx_reg  <= sample_in.series_index;
            s1_time_reg <= sample_in.sample_time;
            s1_bits_reg <= sample_in.sample_bits;
        end
    end

    // series in use: zero counts as one, large counts saturate
    always_comb
    begin
        for (int i = 0; i < kwm_pkg::MAX_SERIES; i++)
        begin
            in_use[i] = (i == 0) || (int'(series_count_reg) > i);
        end
    end

    // take the beat into the head set
    assign idx_bit      = kwm_pkg::mask_t'(1) << s1_idx_reg;
    assign hit          = !end_sent_reg && in_use[s1_idx_reg] &&
                          !(head_valid_reg[s1_idx_reg] || finished_reg[s1_idx_reg]);
    assign take_sample  = hit && (s1_func_reg == kwm_pkg::FUNC_OFFER);
    assign take_finish  = hit && (s1_func_reg == kwm_pkg::FUNC_FINISH);
    assign valid_mid    = head_valid_reg | (take_sample ? idx_bit : '0);
    assign finished_mid = finished_reg   | (take_finish ? idx_bit : '0);
    assign cand         = valid_mid & in_use;
    assign all_ready    = &(valid_mid | finished_mid | ~in_use);
    assign emit         = !end_sent_reg && all_ready;

    // comparator leaves see the incoming sample in place of its empty slot
    always_comb
    begin
        for (int i = 0; i < kwm_pkg::MAX_SERIES; i++)
        begin
            leaf_time[i] = (take_sample && (s1_idx_reg == kwm_pkg::IDX_W'(i))) ?
                           s1_time_reg : head_time_reg[i];
        end
    end

    kwm_pick u_pick
    (
        .cand       (cand),
        .leaf_time  (leaf_time),
        .descending (descending_reg),
        .pick       (pick)
    );

    assign win_time = leaf_time[pick.idx];
    assign win_bits = (take_sample && (s1_idx_reg == pick.idx)) ?
                      s1_bits_reg : head_value_reg[pick.idx];

    // next merge state
    always_comb
    begin
        head_valid_next = head_valid_reg;
        finished_next   = finished_reg;
        end_sent_next   = end_sent_reg;
        if (proc_go)
        begin
            head_valid_next = valid_mid;
            finished_next   = finished_mid;
            if (emit && pick.found)
            begin
                head_valid_next = valid_mid & ~(kwm_pkg::mask_t'(1) << pick.idx);
            end
            else if (emit)
            begin
                end_sent_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            finished_reg   <= '0;
            end_sent_reg   <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            finished_reg   <= finished_next;
            end_sent_reg   <= end_sent_next;
        end
    end

    // head storage
    always_ff @(posedge clk)
    begin
        if (proc_go && take_sample)
        begin
            head_time_reg[s1_idx_reg]  <= s1_time_reg;
            head_value_reg[s1_idx_reg] <= s1_bits_reg;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !merge_out.ready;
        if (proc_go && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && emit)
        begin
            out_time_reg   <= pick.found ? win_time : '0;
            out_bits_reg   <= pick.found ? win_bits : '0;
            out_series_reg <= pick.found ? pick.idx : '0;
            out_end_reg    <= !pick.found;
        end
    end

    assign merge_out.valid         = out_valid_reg;
    assign merge_out.out_time      = out_time_reg;
    assign merge_out.out_bits      = out_bits_reg;
    assign merge_out.refill_series = out_series_reg;
    assign merge_out.merge_end     = out_end_reg;

    // a series never holds a head and an end notice at once
    a_head_or_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg & finished_reg) == '0)
        else $error("series both pending and finished");

    // the end marker carries an all-zero payload
    a_end_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |->
        (out_time_reg == '0 && out_bits_reg == '0 && out_series_reg == '0))
        else $error("end marker with nonzero payload");

    // the end flag stays set until reset
    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        end_sent_reg |=> end_sent_reg)
        else $error("end flag dropped");

    // setting the end flag loads the end marker into the result register
    a_end_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(end_sent_reg) |-> (out_valid_reg && out_end_reg))
        else $error("end flag set without end marker");

    // a sample result names a series in use
    a_refill_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_end_reg) |-> in_use[out_series_reg])
        else $error("refill series outside the series in use");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                      func;
        logic [kwm_pkg::IDX_W-1:0] series;
        kwm_pkg::stamp_t           stamp;
        kwm_pkg::sample_t          payload;
    } offer_t;

    typedef struct packed {
        kwm_pkg::stamp_t           stamp;
        kwm_pkg::sample_t          payload;
        logic [kwm_pkg::IDX_W-1:0] series;
        logic                      last;
    } merged_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [kwm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kwm_pkg::CFG_DATA_W-1:0]  cfg_data;

    kwm_in_if  offer_bus ();
    kwm_out_if merged_bus ();

    kway_timestamp_merge_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (offer_bus),
        .merge_out (merged_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending input beats and merged beats still owed by the block
    offer_t  offer_q[$];
    merged_t merged_q[$];

    // shadow of the merge state
    kwm_pkg::stamp_t           held_stamp[kwm_pkg::MAX_SERIES];
    kwm_pkg::sample_t          held_payload[kwm_pkg::MAX_SERIES];
    kwm_pkg::mask_t            held_mask   = '0;
    kwm_pkg::mask_t            done_mask   = '0;
    bit                        merge_over  = 1'b0;
    logic [kwm_pkg::CNT_W-1:0] cfg_count   = 5'd1;
    logic                      cfg_desc    = 1'b0;

    bit          calm      = 1'b0;
    bit          hold_off  = 1'b0;
    int unsigned src_gap   = 0;
    int unsigned sink_gap  = 0;
    int unsigned beats_in  = 0;
    int unsigned errors    = 0;
    int unsigned cycle_cnt = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // number of series that currently take part
    function automatic int series_live();
        int n;
        n = int'(cfg_count);
        if (n < 1) n = 1;
        if (n > kwm_pkg::MAX_SERIES) n = kwm_pkg::MAX_SERIES;
        return n;
    endfunction

    // take one beat into the shadow state, return 1 when a merged beat results
    function automatic bit predict_merge(input offer_t o, output merged_t r, output bit took);
        int n;
        int best;
        bit full;
        r    = '0;
        took = 1'b0;
        best = -1;
        full = 1'b1;
        if (merge_over) return 1'b0;
        n = series_live();
        if (int'(o.series) < n && !held_mask[o.series] && !done_mask[o.series])
        begin
            took = 1'b1;
            if (o.func == kwm_pkg::FUNC_OFFER)
            begin
                held_stamp[o.series]   = o.stamp;
                held_payload[o.series] = o.payload;
                held_mask[o.series]    = 1'b1;
            end
            else
            begin
                done_mask[o.series] = 1'b1;
            end
        end
        // every live series needs a head or an end notice
        for (int i = 0; i < n; i++)
        begin
            if (!held_mask[i] && !done_mask[i])
            begin
                full = 1'b0;
                break;
            end
            if (held_mask[i])
            begin
                if (best < 0)
                    best = i;
                else if (cfg_desc ? held_stamp[i] > held_stamp[best]
                                  : held_stamp[i] < held_stamp[best])
                    best = i;
            end
        end
        if (!full) return 1'b0;
        if (best >= 0)
        begin
            r.stamp          = held_stamp[best];
            r.payload        = held_payload[best];
            r.series         = 4'(best);
            held_mask[best]  = 1'b0;
        end
        else
        begin
            r.last     = 1'b1;
            merge_over = 1'b1;
        end
        return 1'b1;
    endfunction

    // random live series with neither head nor end notice, -1 if none
    function automatic int pick_open();
        int n;
        int cnt;
        int k;
        n   = series_live();
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (!held_mask[i] && !done_mask[i]) cnt++;
        if (cnt == 0) return -1;
        k = $urandom_range(0, cnt - 1);
        for (int i = 0; i < n; i++)
        begin
            if (!held_mask[i] && !done_mask[i])
            begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    // timestamps lean toward extremes and small values so ties happen
    function automatic kwm_pkg::stamp_t rand_stamp();
        case ($urandom_range(0, 5))
            0: return kwm_pkg::stamp_t'($urandom_range(0, 3));
            1: return '1 - kwm_pkg::stamp_t'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic offer_item(input logic f, input logic [kwm_pkg::IDX_W-1:0] s,
                              input kwm_pkg::stamp_t t, input kwm_pkg::sample_t p,
                              output bit took);
        offer_t  o;
        merged_t r;
        o.func    = f;
        o.series  = s;
        o.stamp   = t;
        o.payload = p;
        offer_q.push_back(o);
        if (predict_merge(o, r, took)) merged_q.push_back(r);
    endtask

    task automatic write_reg(input logic [kwm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [kwm_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == kwm_pkg::CFG_SERIES_COUNT)
            cfg_count = val;
        else
            cfg_desc = val[0];
    endtask

    // wait until nothing is in flight, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        while (offer_q.size() != 0 || offer_bus.valid || merged_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one merge phase under a fixed setting
    task automatic run_phase(input int count, input int desc, input int n_items,
                             input bit wind_down);
        int                        taken;
        int                        k;
        logic                      f;
        logic [kwm_pkg::IDX_W-1:0] s;
        bit                        took;
        taken = 0;
        settle();
        write_reg(kwm_pkg::CFG_SERIES_COUNT, 5'(count));
        write_reg(kwm_pkg::CFG_DESCENDING, 5'(desc));
        while (taken < n_items && !merge_over)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                // noise: end notices only where they are dropped, except when winding down
                s = 4'($urandom_range(0, 15));
                f = kwm_pkg::FUNC_OFFER;
                if (int'(s) >= series_live() || held_mask[s] || done_mask[s] || wind_down)
                    f = 1'($urandom_range(0, 1));
            end
            else
            begin
                k = pick_open();
                if (k < 0)
                begin
                    // all live series full: a dropped beat still triggers the pick
                    s = 4'($urandom_range(0, series_live() - 1));
                    f = kwm_pkg::FUNC_OFFER;
                end
                else
                begin
                    s = 4'(k);
                    f = (wind_down && $urandom_range(0, 3) == 0) ? kwm_pkg::FUNC_FINISH
                                                                 : kwm_pkg::FUNC_OFFER;
                end
            end
            offer_item(f, s, rand_stamp(), {$urandom, $urandom}, took);
            if (took) taken++;
        end
    endtask

    task automatic report(input string what, input merged_t want, input merged_t got);
        errors++;
        if (errors <= 10)
            $display({"%s: expected stamp %h payload %h series %0d end %0b, ",
                      "got stamp %h payload %h series %0d end %0b"},
                     what, want.stamp, want.payload, want.series, want.last,
                     got.stamp, got.payload, got.series, got.last);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        offer_t o;
        if (!rst_n)
        begin
            offer_bus.valid        <= 1'b0;
            offer_bus.func         <= kwm_pkg::FUNC_OFFER;
            offer_bus.series_index <= '0;
            offer_bus.sample_time  <= '0;
            offer_bus.sample_bits  <= '0;
            src_gap                <= 0;
        end
        else if (!offer_bus.valid || offer_bus.ready)
        begin
            if (offer_bus.valid) beats_in <= beats_in + 1;
            if (src_gap != 0)
            begin
                offer_bus.valid <= 1'b0;
                src_gap         <= src_gap - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                offer_bus.valid <= 1'b0;
                src_gap         <= $urandom_range(0, 3);
            end
            else if (offer_q.size() != 0)
            begin
                o = offer_q.pop_front();
                offer_bus.valid        <= 1'b1;
                offer_bus.func         <= o.func;
                offer_bus.series_index <= o.series;
                offer_bus.sample_time  <= o.stamp;
                offer_bus.sample_bits  <= o.payload;
            end
            else
            begin
                offer_bus.valid <= 1'b0;
            end
        end
    end

    // output monitor and ready control
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        merged_t want;
        merged_t got;
        if (!rst_n)
        begin
            merged_bus.ready <= 1'b0;
            sink_gap         <= 0;
        end
        else
        begin
            // check each merged beat against the oldest expectation
            if (merged_bus.valid && merged_bus.ready)
            begin
                got.stamp   = merged_bus.out_time;
                got.payload = merged_bus.out_bits;
                got.series  = merged_bus.refill_series;
                got.last    = merged_bus.merge_end;
                if (merged_q.size() == 0)
                begin
                    report("unexpected beat", '0, got);
                end
                else
                begin
                    want = merged_q.pop_front();
                    if (got.stamp !== want.stamp || got.payload !== want.payload ||
                        got.series !== want.series || got.last !== want.last)
                        report("mismatch", want, got);
                end
            end
            // ready with random stall bursts
            if (hold_off)
            begin
                merged_bus.ready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                merged_bus.ready <= 1'b0;
                sink_gap         <= sink_gap - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                merged_bus.ready <= 1'b0;
                sink_gap         <= $urandom_range(0, 3);
            end
            else
            begin
                merged_bus.ready <= 1'b1;
            end
        end
    end

    // long output stall so the block backs up into its input
    initial
    begin
        wait (beats_in >= 700);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("kway_timestamp_merge_unit verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin : stim_blk
        bit              took;
        int              k;
        kwm_pkg::stamp_t t;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // count of zero behaves as one series
        write_reg(kwm_pkg::CFG_SERIES_COUNT, 5'd0);
        write_reg(kwm_pkg::CFG_DESCENDING, 5'd0);
        offer_item(kwm_pkg::FUNC_OFFER, 4'd0, '0, '1, took);
        offer_item(kwm_pkg::FUNC_OFFER, 4'd1, '1, '1, took);
        offer_item(kwm_pkg::FUNC_FINISH, 4'd15, '1, '0, took);
        offer_item(kwm_pkg::FUNC_OFFER, 4'd0, '1, '0, took);

        // count above the maximum saturates, descending, ties on the top stamp
        settle();
        write_reg(kwm_pkg::CFG_SERIES_COUNT, 5'd31);
        write_reg(kwm_pkg::CFG_DESCENDING, 5'd1);
        for (int i = 0; i < kwm_pkg::MAX_SERIES; i++)
        begin
            if (i == 0)
                t = '0;
            else if (i == 3 || i == 9)
                t = '1;
            else if (i == 12)
                t = 64'h8000_0000_0000_0000;
            else
                t = {$urandom, $urandom};
            offer_item(kwm_pkg::FUNC_OFFER, 4'(i), t,
                       (i % 2 != 0) ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA, took);
        end
        // beat for a series that still holds its head is dropped
        offer_item(kwm_pkg::FUNC_OFFER, 4'd9, '0, '0, took);
        for (int j = 0; j < 2; j++)
        begin
            k = pick_open();
            offer_item(kwm_pkg::FUNC_OFFER, 4'(k), '1, {$urandom, $urandom}, took);
        end

        // random merge phases across settings
        run_phase(16, 0, 210, 1'b0);
        run_phase(5, 1, 210, 1'b0);
        run_phase(2, 0, 210, 1'b0);
        run_phase(16, 1, 210, 1'b0);
        run_phase(1, 0, 210, 1'b0);
        run_phase(9, 0, 210, 1'b0);
        run_phase(31, 1, 210, 1'b0);
        calm <= 1'b1;
        run_phase(12, 1, 210, 1'b0);

        // exhaust every series down to the end marker
        run_phase(16, 0, 100000, 1'b1);

        // everything after the end marker is dropped
        for (int j = 0; j < 4; j++)
            offer_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_stamp(),
                       {$urandom, $urandom}, took);

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && merged_q.size() == 0)
            $display("kway_timestamp_merge_unit verification clean");
        else
            $display("kway_timestamp_merge_unit verification failed");
        $finish;
    end

endmodule
